>>> hdl/rsr_pkg.sv
// ----------------------------------------------------------------------------
// rsr_pkg
// Shared widths, constants, register codes and types of the rotor speed
// ramp and run-up unit.
// ----------------------------------------------------------------------------
package rsr_pkg;

    // fixed field widths
    localparam int DESIRED_W = 10;
    localparam int DRIVE_W   = 10;
    localparam int LEVEL_W   = 18;
    localparam int MODE_W    = 2;
    localparam int CFG_IDX_W = 2;

    // default number of fractional bits of a level
    localparam int FRAC_BITS_DEF = 8;

    localparam logic [LEVEL_W-1:0]   LEVEL_MAX   = '1;
    localparam logic [DESIRED_W-1:0] SPEED_LIMIT = 10'd1000;

    // speed modes
    localparam logic [MODE_W-1:0] MODE_NONE = 2'd0;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEP  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RUNUP_STEP = 2'd2;

    // register reset values
    localparam logic [MODE_W-1:0]  MODE_RST  = 2'd1;
    localparam logic [LEVEL_W-1:0] RAMP_RST  = 18'd2560;
    localparam logic [LEVEL_W-1:0] RUNUP_RST = 18'd256;

    typedef struct packed {
        logic [MODE_W-1:0]  speed_mode;
        logic [LEVEL_W-1:0] ramp_step;
        logic [LEVEL_W-1:0] runup_step;
    } cfg_t;

    typedef struct packed {
        logic                 armed;
        logic [DESIRED_W-1:0] speed_cmd;
    } item_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] drive_level;
        logic [LEVEL_W-1:0] estimate_level;
        logic               runup_done;
    } state_t;

    typedef struct packed {
        logic [DRIVE_W-1:0] drive_value;
        logic               drive_written;
        logic [LEVEL_W-1:0] speed_estimate;
        logic               runup_complete;
    } result_t;

endpackage

>>> hdl/rsr_if.sv
// ----------------------------------------------------------------------------
// rsr interfaces
// Valid/ready channels of the rotor speed ramp and run-up unit: tick
// requests, result requests and register writes.
// ----------------------------------------------------------------------------
interface rsr_tick_if;
    logic                           valid;
    logic                           ready;
    logic                           armed;
    logic [rsr_pkg::DESIRED_W-1:0]  speed_cmd;

    modport source (output valid, armed, speed_cmd, input ready);
    modport sink   (input valid, armed, speed_cmd, output ready);
endinterface

interface rsr_result_if;
    logic                         valid;
    logic                         ready;
    logic [rsr_pkg::DRIVE_W-1:0]  drive_value;
    logic                         drive_written;
    logic [rsr_pkg::LEVEL_W-1:0]  speed_estimate;
    logic                         runup_complete;

    modport source (output valid, drive_value, drive_written, speed_estimate,
                    runup_complete, input ready);
    modport sink   (input valid, drive_value, drive_written, speed_estimate,
                    runup_complete, output ready);
endinterface

interface rsr_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [rsr_pkg::CFG_IDX_W-1:0]  index;
    logic [rsr_pkg::LEVEL_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> hdl/rotor_speed_ramp_runup_unit.sv
// ----------------------------------------------------------------------------
// rotor_speed_ramp_runup_unit
// Rotor speed ramp and run-up tracker, one control tick per request.
// ----------------------------------------------------------------------------
// Each tick request (armed flag, requested speed) produces exactly one result
// request carrying the drive value, the write flag, the speed estimate and
// the run-up complete flag. The unit takes one tick per clock cycle while
// the result side keeps up. A tick is held in the input register, then goes
// through the clamp/ramp/run-up update (adds and compares) into the result
// register, which also writes the drive and estimate state. The result
// register decouples the two sides, so a new tick is taken while a result
// waits; when the result side stalls and both registers are full the unit
// holds off new ticks.
// Registers (speed_mode, ramp_step, runup_step) are written through the
// cfg channel, which is always ready; write them only while no tick is in
// flight. No clearing pass is needed after reset.
module rotor_speed_ramp_runup_unit #(
    parameter int FRAC_BITS = rsr_pkg::FRAC_BITS_DEF
)
(
    input  logic            clk,
    input  logic            rst_n,
    rsr_tick_if.sink        tick,
    rsr_result_if.source    result,
    rsr_cfg_if.sink         cfg
);

    // configuration registers
    rsr_pkg::cfg_t     regs;

    // input stage
    logic              s1_valid_reg;
    logic              s1_valid_next;
    rsr_pkg::item_t    s1_item_reg;

    // result stage
    logic              s2_valid_reg;
    logic              s2_valid_next;
    rsr_pkg::result_t  s2_res_reg;

    // drive, estimate and run-up state
    rsr_pkg::state_t   state_reg;
    rsr_pkg::state_t   state_next;
    rsr_pkg::result_t  res_next;

    logic              tick_take;
    logic              advance;

    rsr_cfg u_cfg
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    rsr_core #(
        .FRAC_BITS (FRAC_BITS)
    ) u_core
    (
        .cfg        (regs),
        .state      (state_reg),
        .item       (s1_item_reg),
        .state_next (state_next),
        .result     (res_next)
    );

    // the input stage moves on when the result register is empty or drains
    assign advance    = s1_valid_reg && (!s2_valid_reg || result.ready);
    assign tick.ready = !s1_valid_reg || advance;
    assign tick_take  = tick.valid && tick.ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (tick_take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end

        s2_valid_next = s2_valid_reg;
        if (advance)
        begin
            s2_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            s2_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            state_reg    <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            // state follows each tick exactly once, in order
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (tick_take)
        begin
            s1_item_reg.armed     <= tick.armed;
            s1_item_reg.speed_cmd <= tick.speed_cmd;
        end
        if (advance)
        begin
            s2_res_reg <= res_next;
        end
    end

    assign result.valid          = s2_valid_reg;
    assign result.drive_value    = s2_res_reg.drive_value;
    assign result.drive_written  = s2_res_reg.drive_written;
    assign result.speed_estimate = s2_res_reg.speed_estimate;
    assign result.runup_complete = s2_res_reg.runup_complete;

endmodule

>>> hdl/rsr_cfg.sv
// ----------------------------------------------------------------------------
// rsr_cfg
// Configuration register file: speed mode, ramp step and run-up step.
// ----------------------------------------------------------------------------
module rsr_cfg
(
    input  logic            clk,
    input  logic            rst_n,
    rsr_cfg_if.sink         cfg,
    output rsr_pkg::cfg_t   regs
);

    rsr_pkg::cfg_t regs_reg;
    logic          wr_en;

    assign cfg.ready = 1'b1;
    assign wr_en     = cfg.valid && cfg.ready;
    assign regs      = regs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.speed_mode <= rsr_pkg::MODE_RST;
            regs_reg.ramp_step  <= rsr_pkg::RAMP_RST;
            regs_reg.runup_step <= rsr_pkg::RUNUP_RST;
        end
        else if (wr_en)
        begin
            unique case (cfg.index)
                rsr_pkg::REG_SPEED_MODE: regs_reg.speed_mode <= cfg.data[rsr_pkg::MODE_W-1:0];
                rsr_pkg::REG_RAMP_STEP:  regs_reg.ramp_step  <= cfg.data;
                rsr_pkg::REG_RUNUP_STEP: regs_reg.runup_step <= cfg.data;
                default:                 ; // unused index
            endcase
        end
    end

endmodule

>>> hdl/rsr_core.sv
// ----------------------------------------------------------------------------
// rsr_core
// Per-tick update: target clamp, drive ramp, estimate run-up and flag.
// ----------------------------------------------------------------------------
module rsr_core #(
    parameter int FRAC_BITS = rsr_pkg::FRAC_BITS_DEF
)
(
    input  rsr_pkg::cfg_t     cfg,
    input  rsr_pkg::state_t   state,
    input  rsr_pkg::item_t    item,
    output rsr_pkg::state_t   state_next,
    output rsr_pkg::result_t  result
);

    localparam int LW  = rsr_pkg::LEVEL_W;
    localparam int SHW = rsr_pkg::DESIRED_W + FRAC_BITS;
    localparam int XW  = ((SHW > LW) ? SHW : LW) + 1;

    logic [rsr_pkg::DESIRED_W-1:0] desired_clamped;
    logic [XW-1:0]                 raw_wide;
    logic [XW-1:0]                 tgt_wide;
    logic [LW-1:0]                 raw_level;
    logic [LW-1:0]                 target;
    logic                          ramping;
    logic [LW-1:0]                 d_base;
    logic [LW:0]                   d_up;
    logic [LW-1:0]                 d_new;
    logic [LW:0]                   e_up;
    logic [LW-1:0]                 e_diff;
    logic [LW-1:0]                 e_new;
    logic                          done_set;
    logic                          written;
    logic [LW-1:0]                 drive_shift;

    assign ramping = (cfg.speed_mode != rsr_pkg::MODE_NONE);

    // requested speed to fixed point, saturating at the level range
    assign desired_clamped = (item.speed_cmd > rsr_pkg::SPEED_LIMIT) ?
                             rsr_pkg::SPEED_LIMIT : item.speed_cmd;
    assign raw_wide  = XW'(item.speed_cmd) << FRAC_BITS;
    assign tgt_wide  = XW'(desired_clamped) << FRAC_BITS;
    assign raw_level = (raw_wide > XW'(rsr_pkg::LEVEL_MAX)) ?
                       rsr_pkg::LEVEL_MAX : raw_wide[LW-1:0];
    assign target    = (tgt_wide > XW'(rsr_pkg::LEVEL_MAX)) ?
                       rsr_pkg::LEVEL_MAX : tgt_wide[LW-1:0];

    // drive: jump to the estimate, then ramp up, never past the target
    assign d_base = (state.drive_level < state.estimate_level) ?
                    state.estimate_level : state.drive_level;
    assign d_up   = {1'b0, d_base} + {1'b0, cfg.ramp_step};
    assign d_new  = (state.drive_level < target) ?
                    ((d_up > {1'b0, target}) ? target : d_up[LW-1:0]) : target;

    // estimate toward the new drive
    assign e_up   = {1'b0, state.estimate_level} + {1'b0, cfg.runup_step};
    assign e_diff = state.estimate_level - d_new;

    always_comb
    begin
        if (state.estimate_level < d_new)
        begin
            e_new = (e_up > {1'b0, d_new}) ? d_new : e_up[LW-1:0];
        end
        else
        begin
            e_new = (e_diff > cfg.runup_step) ?
                    (state.estimate_level - cfg.runup_step) : d_new;
        end
    end

    assign done_set = state.runup_done || ((target != '0) && (e_new >= target));

    always_comb
    begin
        state_next = state;
        written    = 1'b0;
        if (!ramping)
        begin
            if (item.armed)
            begin
                state_next.drive_level = raw_level;
            end
        end
        else if (!item.armed)
        begin
            state_next.drive_level    = '0;
            state_next.estimate_level = '0;
            written                   = 1'b1;
        end
        else
        begin
            state_next.drive_level    = d_new;
            state_next.estimate_level = e_new;
            state_next.runup_done     = done_set && !((target == '0) && (e_new == '0));
            written                   = 1'b1;
        end
    end

    assign drive_shift           = state_next.drive_level >> FRAC_BITS;
    assign result.drive_value    = drive_shift[rsr_pkg::DRIVE_W-1:0];
    assign result.drive_written  = written;
    assign result.speed_estimate = state_next.estimate_level;
    assign result.runup_complete = !ramping || state_next.runup_done;

endmodule

>>> hdl/rsr_checker.sv
// ----------------------------------------------------------------------------
// rsr_checker
// Port-level assertions of the rotor speed ramp and run-up unit.
// ----------------------------------------------------------------------------
module rsr_checker
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         res_valid,
    input logic                         res_ready,
    input logic [rsr_pkg::DRIVE_W-1:0]  drive_value,
    input logic                         drive_written,
    input logic [rsr_pkg::LEVEL_W-1:0]  speed_estimate,
    input logic                         runup_complete
);

    // stalled result stays offered
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result dropped while stalled");

    // stalled result payload holds
    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(drive_value) && $stable(drive_written)
            && $stable(speed_estimate) && $stable(runup_complete))
        else $error("result payload changed while stalled");

    // a tick with no drive write is mode none, which always reports run-up done
    a_none_complete: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !drive_written |-> runup_complete)
        else $error("run-up flag low in direct mode");

endmodule

bind rotor_speed_ramp_runup_unit rsr_checker u_rsr_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .res_valid      (result.valid),
    .res_ready      (result.ready),
    .drive_value    (result.drive_value),
    .drive_written  (result.drive_written),
    .speed_estimate (result.speed_estimate),
    .runup_complete (result.runup_complete)
);

>>> bench/rsr_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsr_tb_pkg
// Predicting scoreboard of the rotor speed ramp and run-up unit: it keeps
// its own registers and rotor state, works out each tick's result and
// checks the results of the block in order.
// ----------------------------------------------------------------------------
package rsr_tb_pkg;

    import rsr_pkg::*;

    // ramping mode codes, the package names only the direct one
    localparam logic [MODE_W-1:0]    MODE_CHANNEL  = 2'd1;
    localparam logic [MODE_W-1:0]    MODE_SETPOINT = 2'd2;
    localparam logic [MODE_W-1:0]    MODE_SPARE    = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE     = 2'd3;

    localparam int MAX_PRINTED = 30;

    class runup_scoreboard;
        cfg_t    regs;
        state_t  rotor;
        result_t awaited_results[$];
        int      failures;
        int      compared;

        function new();
            regs.speed_mode = MODE_RST;
            regs.ramp_step  = RAMP_RST;
            regs.runup_step = RUNUP_RST;
            rotor           = '0;
            failures        = 0;
            compared        = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [LEVEL_W-1:0] val);
            case (idx)
                REG_SPEED_MODE: regs.speed_mode = val[MODE_W-1:0];
                REG_RAMP_STEP:  regs.ramp_step  = val;
                REG_RUNUP_STEP: regs.runup_step = val;
                default: ;
            endcase
        endfunction

        // whole speed to fixed point, saturated to the level width
        function int unsigned fixed_level(logic [DESIRED_W-1:0] whole);
            int unsigned v;
            v = int'(whole) << FRAC_BITS_DEF;
            return (v > LEVEL_MAX) ? int'(LEVEL_MAX) : v;
        endfunction

        function void note_tick(item_t t);
            int unsigned target;
            int unsigned d;
            int unsigned e;
            bit          written;
            result_t     r;
            written = 1'b0;
            if (regs.speed_mode == MODE_NONE) begin
                if (t.armed)
                    rotor.drive_level = LEVEL_W'(fixed_level(t.speed_cmd));
            end
            else if (!t.armed) begin
                rotor.drive_level    = '0;
                rotor.estimate_level = '0;
                written              = 1'b1;
            end
            else begin
                target = fixed_level((t.speed_cmd > SPEED_LIMIT) ? SPEED_LIMIT
                                                                  : t.speed_cmd);
                d = rotor.drive_level;
                e = rotor.estimate_level;
                // drive: catch up with the estimate, then ramp, never past the target
                if (d < target) begin
                    if (d < e)
                        d = e;
                    d += regs.ramp_step;
                    if (d > target)
                        d = target;
                end
                else
                    d = target;
                // estimate follows the drive by at most one step
                if (e < d) begin
                    e += regs.runup_step;
                    if (e > d)
                        e = d;
                end
                else if (e - d > regs.runup_step)
                    e -= regs.runup_step;
                else
                    e = d;
                if (!rotor.runup_done && target > 0 && e >= target)
                    rotor.runup_done = 1'b1;
                if (rotor.runup_done && target == 0 && e == 0)
                    rotor.runup_done = 1'b0;
                rotor.drive_level    = LEVEL_W'(d);
                rotor.estimate_level = LEVEL_W'(e);
                written              = 1'b1;
            end
            r.drive_value    = DRIVE_W'(rotor.drive_level >> FRAC_BITS_DEF);
            r.drive_written  = written;
            r.speed_estimate = rotor.estimate_level;
            r.runup_complete = (regs.speed_mode == MODE_NONE) || rotor.runup_done;
            awaited_results.push_back(r);
        endfunction

        task flag_mismatch(string what);
            if (failures < MAX_PRINTED)
                $display("mismatch at %0t ns: %s", $time, what);
            failures++;
        endtask

        task check_result(result_t got);
            result_t want;
            if (awaited_results.size() == 0) begin
                flag_mismatch("result request with no tick outstanding");
                return;
            end
            want = awaited_results.pop_front();
            compared++;
            if (got.drive_value !== want.drive_value)
                flag_mismatch($sformatf("drive_value %0d, predicted %0d",
                                        got.drive_value, want.drive_value));
            if (got.drive_written !== want.drive_written)
                flag_mismatch($sformatf("drive_written %b, predicted %b",
                                        got.drive_written, want.drive_written));
            if (got.speed_estimate !== want.speed_estimate)
                flag_mismatch($sformatf("speed_estimate %0d, predicted %0d",
                                        got.speed_estimate, want.speed_estimate));
            if (got.runup_complete !== want.runup_complete)
                flag_mismatch($sformatf("runup_complete %b, predicted %b",
                                        got.runup_complete, want.runup_complete));
        endtask

        task check_drained();
            if (awaited_results.size() != 0)
                flag_mismatch($sformatf("%0d results never arrived",
                                        awaited_results.size()));
        endtask
    endclass

endpackage

>>> bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench of rotor_speed_ramp_runup_unit: directed ticks over the mode and
// step extremes, then randomized ramp sequences under several register
// settings, with random gaps and stalls on both channels and a long result
// stall; every result request is checked against the scoreboard.
// ----------------------------------------------------------------------------
module tb;

    import rsr_pkg::*;
    import rsr_tb_pkg::*;

    localparam int HALF_PERIOD   = 10;
    localparam int CYCLE_LIMIT   = 100000;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_CYCLES  = 8;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_TICKS   = 205;
    localparam int HOLD_PHASE    = 2;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    rsr_tick_if   tick_bus ();
    rsr_result_if result_bus ();
    rsr_cfg_if    cfg_bus ();

    rotor_speed_ramp_runup_unit dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .tick   (tick_bus),
        .result (result_bus),
        .cfg    (cfg_bus)
    );

    runup_scoreboard sb = new();

    int unsigned cycle_count   = 0;
    bit          idle_on       = 1'b1;
    int          holds_asked   = 0;
    int          holds_done    = 0;
    int          hold_left     = 0;
    int          ticks_sent    = 0;
    int          settings_used = 0;
    result_t     seen;

    always #(HALF_PERIOD) clk = ~clk;

    // every input known from time zero
    initial
    begin
        tick_bus.valid     = 1'b0;
        tick_bus.armed     = 1'b0;
        tick_bus.speed_cmd = '0;
        cfg_bus.valid      = 1'b0;
        cfg_bus.index      = REG_SPEED_MODE;
        cfg_bus.data       = '0;
        result_bus.ready   = 1'b0;
    end

    // free-running cycle count for the watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles", cycle_count);
        $display("[rotor_speed_ramp_runup_unit] ERROR");
        $finish;
    end

    // result side: random back-pressure, plus a long hold when one is asked
    always @(negedge clk)
    begin
        if (holds_asked != holds_done) begin
            holds_done = holds_asked;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            result_bus.ready = 1'b0;
            hold_left--;
        end
        else
            result_bus.ready = !(idle_on && $urandom_range(99) < 16);
    end

    // every accepted result request goes to the scoreboard in arrival order
    always @(posedge clk)
    begin
        if (rst_n && result_bus.valid && result_bus.ready) begin
            seen.drive_value    = result_bus.drive_value;
            seen.drive_written  = result_bus.drive_written;
            seen.speed_estimate = result_bus.speed_estimate;
            seen.runup_complete = result_bus.runup_complete;
            sb.check_result(seen);
        end
    end

    // offer one tick request, maybe after a random gap; returns at the
    // falling edge after the accepting edge with valid still high
    task automatic send_tick(input logic armed, input logic [DESIRED_W-1:0] speed);
        item_t t;
        t.armed     = armed;
        t.speed_cmd = speed;
        while (idle_on && $urandom_range(99) < 16) begin
            tick_bus.valid = 1'b0;
            @(negedge clk);
        end
        tick_bus.valid     = 1'b1;
        tick_bus.armed     = armed;
        tick_bus.speed_cmd = speed;
        do
            @(posedge clk);
        while (!tick_bus.ready);
        sb.note_tick(t);
        ticks_sent++;
        @(negedge clk);
    endtask

    // stop offering and let every outstanding result come back
    task automatic wait_idle();
        tick_bus.valid = 1'b0;
        while (sb.awaited_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [LEVEL_W-1:0] val);
        cfg_bus.valid = 1'b1;
        cfg_bus.index = idx;
        cfg_bus.data  = val;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        sb.set_reg(idx, val);
        @(negedge clk);
    endtask

    // registers only change with the pipeline empty
    task automatic apply_setting(input logic [MODE_W-1:0] mode,
                                 input logic [LEVEL_W-1:0] ramp,
                                 input logic [LEVEL_W-1:0] runup);
        wait_idle();
        write_reg(REG_SPEED_MODE, LEVEL_W'(mode));
        write_reg(REG_RAMP_STEP, ramp);
        write_reg(REG_RUNUP_STEP, runup);
        cfg_bus.valid = 1'b0;
        settings_used++;
    endtask

    // step sizes: mostly ones that reach full speed in tens of ticks
    function automatic logic [LEVEL_W-1:0] pick_step();
        int pick;
        pick = $urandom_range(99);
        if (pick < 4)
            return '0;
        else if (pick < 10)
            return LEVEL_W'(1);
        else if (pick < 16)
            return ($urandom_range(1) != 0) ? LEVEL_W'(256000) : LEVEL_MAX;
        else if (pick < 70)
            return LEVEL_W'($urandom_range(25600, 256));
        else
            return LEVEL_W'($urandom_range(LEVEL_MAX, 1));
    endfunction

    // random ticks: mostly armed runs holding one speed long enough to ramp
    // up and finish the run-up, the rest disarm bursts and noise
    task automatic run_phase(input int count);
        int                   left;
        int                   len;
        int                   pick;
        logic [DESIRED_W-1:0] speed;
        left = count;
        while (left > 0) begin
            pick = $urandom_range(99);
            if (pick < 72) begin
                pick = $urandom_range(99);
                if (pick < 12)
                    speed = '0;
                else if (pick < 24)
                    speed = ($urandom_range(1) != 0) ? SPEED_LIMIT
                                                     : DESIRED_W'($urandom_range(1023, 1001));
                else
                    speed = DESIRED_W'($urandom_range(1023));
                len = $urandom_range(40, 4);
                repeat (len) send_tick(1'b1, speed);
            end
            else if (pick < 86) begin
                len = $urandom_range(4, 1);
                repeat (len) send_tick(1'b0, DESIRED_W'($urandom_range(1023)));
            end
            else begin
                len = $urandom_range(8, 1);
                repeat (len)
                    send_tick(1'($urandom_range(1)), DESIRED_W'($urandom_range(1023)));
            end
            left -= len;
        end
    endtask

    initial
    begin
        logic [MODE_W-1:0] mode;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        // reset registers: disarmed tick, clamp above the limit, drop to zero
        send_tick(1'b0, '0);
        send_tick(1'b1, 10'd1023);
        send_tick(1'b1, SPEED_LIMIT);
        send_tick(1'b1, 10'd1001);
        send_tick(1'b1, '0);

        // largest steps: one-tick run-up, flag set, cleared when back at zero,
        // kept over a disarmed tick; a write to the spare index is ignored
        apply_setting(MODE_SETPOINT, LEVEL_W'(256000), LEVEL_MAX);
        write_reg(REG_SPARE, LEVEL_MAX);
        cfg_bus.valid = 1'b0;
        send_tick(1'b1, SPEED_LIMIT);
        send_tick(1'b1, 10'd1023);
        send_tick(1'b1, '0);
        send_tick(1'b1, 10'd1);
        send_tick(1'b0, 10'd700);
        send_tick(1'b1, '0);

        // direct mode: drive follows the request unclamped, nothing written
        apply_setting(MODE_NONE, RAMP_RST, RUNUP_RST);
        send_tick(1'b1, 10'd1023);
        send_tick(1'b0, 10'd555);
        send_tick(1'b1, '0);
        send_tick(1'b1, SPEED_LIMIT);

        // spare mode ramps too; smallest steps, drive above target drops at once
        apply_setting(MODE_SPARE, LEVEL_W'(1), LEVEL_W'(1));
        send_tick(1'b1, 10'd1023);
        send_tick(1'b1, 10'd1023);
        send_tick(1'b1, 10'd512);
        send_tick(1'b0, 10'd1023);

        // zero steps freeze both ramps
        apply_setting(MODE_CHANNEL, '0, '0);
        send_tick(1'b1, 10'd800);
        send_tick(1'b1, 10'd800);
        send_tick(1'b1, 10'd300);

        // random settings; the first phase runs without any idling and one
        // phase starts under a long result stall so the block backs up
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            idle_on = (p != 0);
            if ($urandom_range(99) < 15)
                mode = MODE_NONE;
            else
                mode = MODE_W'($urandom_range(3, 1));
            apply_setting(mode, pick_step(), pick_step());
            if (p == HOLD_PHASE)
                holds_asked++;
            run_phase(PHASE_TICKS);
        end

        wait_idle();
        sb.check_drained();
        $display("ran %0d tick requests under %0d register settings", ticks_sent,
                 settings_used);
        $display("compared %0d result requests, %0d mismatches", sb.compared,
                 sb.failures);
        if (sb.failures == 0)
            $display("[rotor_speed_ramp_runup_unit] OK");
        else
            $display("[rotor_speed_ramp_runup_unit] ERROR");
        $finish;
    end

endmodule

>>> files.f
hdl/rsr_pkg.sv
hdl/rsr_if.sv
hdl/rsr_cfg.sv
hdl/rsr_core.sv
hdl/rotor_speed_ramp_runup_unit.sv
hdl/rsr_checker.sv
bench/rsr_tb_pkg.sv
bench/tb.sv
